// ----- hw/rtl/scaler_event_word_decoder_top_macros.svh -----
// Assertion macros for the scaler event word decoder.
`ifndef SCALER_EVENT_WORD_DECODER_TOP_MACROS_SVH
`define SCALER_EVENT_WORD_DECODER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication under synchronous active-low reset.
`define SEWD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication under synchronous active-low reset.
`define SEWD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SEWD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define SEWD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/sewd_pkg.sv -----
// Shared types and constants of the scaler event word decoder.
package sewd_pkg;

    localparam int CHANNELS   = 32;
    localparam int CH_AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int WORD_W     = 32;
    localparam int CH_W       = 5;
    localparam int GEO_W      = 5;
    localparam int CNT_W      = 26;
    localparam int WL_W       = 6;
    localparam int TNUM_W     = 16;
    localparam int TTYPE_W    = 2;
    localparam int KIND_W     = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 26;

    localparam int GEO_LSB    = 27;
    localparam int MARKER_POS = 26;
    localparam int NCH_LSB    = 18;
    localparam int TTYPE_LSB  = 16;
    localparam int TNUM_LSB   = 0;
    localparam int CNT_LSB    = 0;

    localparam logic [CNT_W-1:0] MAX_INC_RST = CNT_W'(200);

    localparam logic [CFG_IDX_W-1:0] CFG_GEO     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_INC = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_HDR_OK   = 3'd0,
        KIND_CH_DATA  = 3'd1,
        KIND_CH_SKIP  = 3'd2,
        KIND_GEO_MISS = 3'd3,
        KIND_XTRA_HDR = 3'd4
    } t_kind;

    // Decoded word, handed from the header tracker to the count stage.
    typedef struct packed {
        t_kind               kind;
        logic [CH_W-1:0]     ch;
        logic [CNT_W-1:0]    cnt;
        logic [TNUM_W-1:0]   tnum;
        logic [TTYPE_W-1:0]  ttype;
        logic                evt_end;
        logic                upd;
    } t_dec;

endpackage

// ----- hw/rtl/sewd_in_if.sv -----
// Input word channel of the scaler event word decoder.
interface sewd_in_if;
    import sewd_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

// ----- hw/rtl/sewd_out_if.sv -----
// Result word channel of the scaler event word decoder.
interface sewd_out_if;
    import sewd_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [CH_W-1:0]    channel;
    logic [CNT_W-1:0]   count_value;
    logic [CNT_W-1:0]   increment;
    logic               increment_nonzero;
    logic [TNUM_W-1:0]  trigger_number;
    logic [TTYPE_W-1:0] trigger_type;
    logic               event_end;

    modport source (
        output valid, output kind, output channel, output count_value, output increment,
        output increment_nonzero, output trigger_number, output trigger_type,
        output event_end, input ready
    );
    modport sink (
        input valid, input kind, input channel, input count_value, input increment,
        input increment_nonzero, input trigger_number, input trigger_type,
        input event_end, output ready
    );
endinterface

// ----- hw/rtl/sewd_decode.sv -----
// Header tracker: event framing state and per-word field decode.
module sewd_decode (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [sewd_pkg::WORD_W-1:0]   i_word,
    input  logic [sewd_pkg::GEO_W-1:0]    i_geo,
    output sewd_pkg::t_dec                o_dec
);
    import sewd_pkg::*;

    logic [WL_W-1:0]    r_words_left, n_words_left;
    logic [TNUM_W-1:0]  r_trig_num, n_trig_num;
    logic [TTYPE_W-1:0] r_trig_type, n_trig_type;
    logic               marker;
    t_dec               dec;

    assign marker = i_word[MARKER_POS];

    always_comb begin
        dec          = '0;
        n_words_left = r_words_left;
        n_trig_num   = r_trig_num;
        n_trig_type  = r_trig_type;
        if (r_words_left == '0) begin
            if (i_word[GEO_LSB +: GEO_W] != i_geo) begin
                dec.kind    = KIND_GEO_MISS;
                dec.evt_end = 1'b1;
            end else begin
                if (marker) begin
                    n_words_left = i_word[NCH_LSB +: WL_W];
                    n_trig_type  = i_word[TTYPE_LSB +: TTYPE_W];
                    n_trig_num   = i_word[TNUM_LSB +: TNUM_W];
                end else begin
                    n_words_left = '0;
                    n_trig_type  = '0;
                    n_trig_num   = '0;
                end
                dec.kind    = KIND_HDR_OK;
                dec.evt_end = (n_words_left == '0);
                dec.tnum    = n_trig_num;
                dec.ttype   = n_trig_type;
            end
        end else begin
            dec.tnum  = r_trig_num;
            dec.ttype = r_trig_type;
            if (marker) begin
                // abort: header marker where channel data belongs
                dec.kind     = KIND_XTRA_HDR;
                dec.evt_end  = 1'b1;
                n_words_left = '0;
            end else begin
                n_words_left = r_words_left - WL_W'(1);
                dec.evt_end  = (n_words_left == '0);
                dec.ch       = i_word[GEO_LSB +: CH_W];
                dec.cnt      = i_word[CNT_LSB +: CNT_W];
                if ({1'b0, dec.ch} >= (CH_W+1)'(CHANNELS)) begin
                    dec.kind = KIND_CH_SKIP;
                end else begin
                    dec.kind = KIND_CH_DATA;
                    dec.upd  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words_left <= '0;
            r_trig_num   <= '0;
            r_trig_type  <= '0;
        end else if (i_accept) begin
            r_words_left <= n_words_left;
            r_trig_num   <= n_trig_num;
            r_trig_type  <= n_trig_type;
        end
    end

    assign o_dec = dec;

endmodule

// ----- hw/rtl/sewd_cnt_mem.sv -----
// Previous-count store: registered read, write-back, valid bits and forwarding.
module sewd_cnt_mem (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [sewd_pkg::CH_AW-1:0]    i_rd_idx,
    input  logic                          i_wr_en,
    input  logic [sewd_pkg::CH_AW-1:0]    i_wr_idx,
    input  logic [sewd_pkg::CNT_W-1:0]    i_wr_data,
    output logic [sewd_pkg::CNT_W-1:0]    o_prev
);
    import sewd_pkg::*;

    logic [CNT_W-1:0]    mem [CHANNELS];
    logic [CHANNELS-1:0] r_valid;
    logic [CNT_W-1:0]    r_rd_q;
    logic                r_rd_vld;
    logic                r_fwd;
    logic [CNT_W-1:0]    r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_idx] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_q     <= mem[i_rd_idx];
            r_fwd_data <= i_wr_data;
        end
    end

    // A write landing on the entry read in the same cycle wins over the stale read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
            r_fwd    <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_valid[i_rd_idx];
                r_fwd    <= i_wr_en && (i_wr_idx == i_rd_idx);
            end
        end
    end

    assign o_prev = r_fwd ? r_fwd_data : (r_rd_vld ? r_rd_q : '0);

endmodule

// ----- hw/rtl/scaler_event_word_decoder_top.sv -----
// Top level of the scaler event word decoder.
//
//  channel   | dir | handshake             | payload
//  ----------+-----+-----------------------+------------------------------------------
//  i_word    | in  | valid/ready           | word[31:0]
//  o_result  | out | valid/ready           | kind, channel, count_value, increment,
//            |     |                       | increment_nonzero, trigger_number/type,
//            |     |                       | event_end
//  config    | in  | i_cfg_we, no stall    | i_cfg_idx: 0 geo_address, 1 max_increment
//
// One word per cycle unless the output stalls; a word moves via stage 1 to o_result.
// Stage 0 decodes the word against the framing registers and reads the previous
// count; stage 1 computes the saturated increment and writes the new count back
// as it moves into the output register.
// Synchronous active-low reset clears framing state, valid bits and the pipeline;
// the count store needs no clearing pass (entries without a valid bit read zero).
// A stalled output holds the output register and stage 1; input ready stays high
// while stage 1 is empty or draining.
`include "scaler_event_word_decoder_top_macros.svh"

module scaler_event_word_decoder_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    sewd_in_if.sink                          i_word,
    sewd_out_if.source                       o_result,
    input  logic                             i_cfg_we,
    input  logic [sewd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sewd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import sewd_pkg::*;

    // configuration
    logic [GEO_W-1:0] r_geo;
    logic [CNT_W-1:0] r_max_inc;

    // stage 0 / stage 1 / output register
    t_dec             dec;
    logic             in_acc;
    logic             r_s1_vld;
    t_dec             r_s1;
    logic             s1_go;
    logic [CNT_W-1:0] prev;
    logic [CNT_W-1:0] diff;
    logic [CNT_W-1:0] inc;

    logic               r_out_vld;
    t_kind              r_out_kind;
    logic [CH_W-1:0]    r_out_ch;
    logic [CNT_W-1:0]   r_out_cnt;
    logic [CNT_W-1:0]   r_out_inc;
    logic               r_out_nz;
    logic [TNUM_W-1:0]  r_out_tnum;
    logic [TTYPE_W-1:0] r_out_ttype;
    logic               r_out_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geo     <= '0;
            r_max_inc <= MAX_INC_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GEO:     r_geo     <= i_cfg_data[GEO_W-1:0];
                CFG_MAX_INC: r_max_inc <= i_cfg_data[CNT_W-1:0];
                default:     ;
            endcase
        end
    end

    // Advance stage 1 whenever the output register is free or being taken.
    assign s1_go          = r_s1_vld && (!r_out_vld || o_result.ready);
    assign i_word.ready   = !r_s1_vld || s1_go;
    assign in_acc         = i_word.valid && i_word.ready;

    sewd_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_acc),
        .i_word   (i_word.word),
        .i_geo    (r_geo),
        .o_dec    (dec)
    );

    sewd_cnt_mem u_cnt_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_idx  (dec.ch[CH_AW-1:0]),
        .i_wr_en   (s1_go && r_s1.upd),
        .i_wr_idx  (r_s1.ch[CH_AW-1:0]),
        .i_wr_data (r_s1.cnt),
        .o_prev    (prev)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_acc) begin
            r_s1_vld <= 1'b1;
        end else if (s1_go) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= dec;
        end
    end

    // Modulo-2^26 difference, clamped at the configured limit.
    assign diff = r_s1.cnt - prev;
    assign inc  = !r_s1.upd ? '0 : ((diff > r_max_inc) ? r_max_inc : diff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_go) begin
            r_out_vld <= 1'b1;
        end else if (o_result.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out_kind  <= r_s1.kind;
            r_out_ch    <= r_s1.ch;
            r_out_cnt   <= r_s1.cnt;
            r_out_inc   <= inc;
            r_out_nz    <= (inc != '0);
            r_out_tnum  <= r_s1.tnum;
            r_out_ttype <= r_s1.ttype;
            r_out_end   <= r_s1.evt_end;
        end
    end

    assign o_result.valid             = r_out_vld;
    assign o_result.kind              = r_out_kind;
    assign o_result.channel           = r_out_ch;
    assign o_result.count_value       = r_out_cnt;
    assign o_result.increment         = r_out_inc;
    assign o_result.increment_nonzero = r_out_nz;
    assign o_result.trigger_number    = r_out_tnum;
    assign o_result.trigger_type      = r_out_ttype;
    assign o_result.event_end         = r_out_end;

    `SEWD_ASSERT_NOW(a_inc_sat, i_clk, i_rst_n, r_out_vld, r_out_inc <= r_max_inc, "increment above limit")
    `SEWD_ASSERT_NOW(a_inc_kind, i_clk, i_rst_n, r_out_vld && r_out_nz, r_out_kind == KIND_CH_DATA, "nonzero increment outside channel data")
    `SEWD_ASSERT_NOW(a_geo_miss, i_clk, i_rst_n, r_out_vld && (r_out_kind == KIND_GEO_MISS), r_out_end && (r_out_tnum == '0) && (r_out_inc == '0), "geo mismatch result not clean")
    `SEWD_ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, r_s1_vld && !s1_go, r_s1_vld && $stable(r_s1), "stalled stage 1 lost its word")

endmodule
